/* hw/rtl/cbc_pkg.sv */
// Shared types and codes for the cartridge bank controller.
// Depends on nothing; imported by every other RTL file of the block.
`default_nettype none

package cbc_pkg;

	// Controller kinds held in the kind configuration register
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_MBC1 = 2'd1;
	localparam logic [1:0] KIND_MBC3 = 2'd2;
	localparam logic [1:0] KIND_MBC5 = 2'd3;

	// Configuration register indexes
	localparam logic CFG_CONTROLLER_KIND = 1'b0;
	localparam logic CFG_HAS_CART_RAM    = 1'b1;
	localparam int   CFG_DATA_W          = 2;

	// Register picked by address bits 13-14
	localparam logic [1:0] REG_RAM_ENABLE = 2'd0;
	localparam logic [1:0] REG_ROM_BANK   = 2'd1;
	localparam logic [1:0] REG_RAM_BANK   = 2'd2;
	localparam logic [1:0] REG_MODE_LATCH = 2'd3;

	// Data byte codes
	localparam logic [7:0] RAM_ENABLE_ON  = 8'h0A;
	localparam logic [7:0] RAM_ENABLE_OFF = 8'h00;
	localparam logic [7:0] LATCH_ARM      = 8'h00;
	localparam logic [7:0] LATCH_FIRE     = 8'h01;

	// Reset values
	localparam logic [8:0] ROM_BANK_RESET = 9'd1;

	typedef struct packed {
		logic [14:0] addr;
		logic [7:0]  wdata;
	} in_item_t;

	typedef struct packed {
		logic [8:0] rom_bank;
		logic       ram_active;
		logic       ram_attached;
		logic [3:0] mapped_ram_bank;
		logic [7:0] selected_ram_bank;
		logic       latch_pulse;
		logic       write_error;
	} out_item_t;

	typedef struct packed {
		logic [8:0] rom_bank;
		logic [7:0] ram_sel;
		logic       ram_en;
		logic       ram_attached;
		logic [3:0] mapped_bank;
		logic       mode;
		logic       latch_armed;
	} bank_state_t;

	typedef struct packed {
		logic pulse;
		logic err;
	} step_flags_t;

endpackage : cbc_pkg

`default_nettype wire

/* hw/rtl/cbc_next_state.sv */
// Next-state decode of the bank registers for one CPU write.
// Depends on cbc_pkg; purely combinational, used by the top level.
`default_nettype none

module cbc_next_state
	import cbc_pkg::*;
(
	input  logic [1:0]  kind,
	input  bank_state_t cur,
	input  in_item_t    item,
	output bank_state_t nxt,
	output step_flags_t flags
);

	logic [1:0] reg_sel;
	logic [7:0] val;
	logic       mbc3;

	assign reg_sel = item.addr[14:13];
	assign val     = item.wdata;
	assign mbc3    = (kind == KIND_MBC3);

	always_comb begin
		nxt         = cur;
		flags.pulse = 1'b0;
		flags.err   = 1'b0;
		unique case (kind)
			KIND_NONE: begin
				flags.err = 1'b1;
			end
			default: begin
				unique case (reg_sel)
					REG_RAM_ENABLE: begin
						if (val == RAM_ENABLE_OFF) begin
							nxt.ram_attached = 1'b0;
							nxt.ram_en       = 1'b0;
						end else if (val == RAM_ENABLE_ON) begin
							nxt.ram_en = 1'b1;
							if (mbc3 && (cur.ram_sel >= 8'd4)) begin
								nxt.ram_attached = 1'b0;
							end else if (!cur.ram_attached) begin
								nxt.ram_attached = 1'b1;
								nxt.mapped_bank  = cur.ram_sel[3:0];
							end
						end
					end
					REG_ROM_BANK: begin
						unique case (kind)
							KIND_MBC1: nxt.rom_bank = {4'd0, val[4:0]};
							KIND_MBC3: nxt.rom_bank = (val == 8'd0) ? ROM_BANK_RESET
								: {1'b0, val};
							default: begin
								// MBC5: bit 12 picks the high bank bit
								if (item.addr[12])
									nxt.rom_bank = {val[0], cur.rom_bank[7:0]};
								else
									nxt.rom_bank = {cur.rom_bank[8], val};
							end
						endcase
					end
					REG_RAM_BANK: begin
						unique case (kind)
							KIND_MBC1: begin
								if (cur.mode) begin
									if ({6'd0, val[1:0]} != cur.ram_sel) begin
										nxt.ram_sel = {6'd0, val[1:0]};
										if (cur.ram_en && !cur.ram_attached) begin
											nxt.ram_attached = 1'b1;
											nxt.mapped_bank  = {2'd0, val[1:0]};
										end
									end
								end else begin
									nxt.rom_bank = {2'd0, val[1:0], cur.rom_bank[4:0]};
								end
							end
							KIND_MBC3: begin
								// clock register select unmaps RAM; 4 to 7 is dropped
								if (val >= 8'd8) begin
									nxt.ram_sel      = val;
									nxt.ram_attached = 1'b0;
								end else if ((val < 8'd4) && (cur.ram_sel != val)) begin
									nxt.ram_sel = val;
									if (cur.ram_en) begin
										nxt.ram_attached = 1'b1;
										nxt.mapped_bank  = val[3:0];
									end else begin
										nxt.ram_attached = 1'b0;
									end
								end
							end
							default: begin
								nxt.ram_sel = {4'd0, val[3:0]};
								if (cur.ram_en) begin
									nxt.ram_attached = 1'b1;
									nxt.mapped_bank  = val[3:0];
								end else begin
									nxt.ram_attached = 1'b0;
								end
							end
						endcase
					end
					default: begin
						unique case (kind)
							KIND_MBC1: nxt.mode = val[0];
							KIND_MBC3: begin
								if (val == LATCH_ARM) begin
									nxt.latch_armed = 1'b0;
								end else if ((val == LATCH_FIRE) && !cur.latch_armed) begin
									nxt.latch_armed = 1'b1;
									flags.pulse     = 1'b1;
								end
							end
							default: ; // MBC5 ignores this range
						endcase
					end
				endcase
			end
		endcase
	end

endmodule : cbc_next_state

`default_nettype wire

/* hw/rtl/cartridge_bank_controller.sv */
// Top level of the cartridge bank controller: input stage, bank state, result stage.
// Depends on cbc_pkg and cbc_next_state.
//
// Use: each input item is one CPU write to the ROM area (address and data byte).
// The result item reports the mapping after that write: ROM bank, RAM enable,
// RAM mapped flag and bank, RAM/clock select, clock latch pulse and an error
// flag set when no controller kind is configured.
// Channels: in_valid/in_stall/in_item and out_valid/out_stall/out_item; an item
// moves at a rising edge with valid high and stall low.
// Path: an accepted item waits in the input register, then its result is offered
// from the result register. Throughput: one item per cycle while out_stall does not
// hold the result; the bank update is a single pass of decode logic between the
// input register and the result register.
// A stalled result is held in the result register while the input register
// still takes one more item; in_stall rises only when both are full.
// Configuration: cfg_we/cfg_index/cfg_wdata, written while no item is in flight.
// Writing has_cart_ram also loads the RAM mapped flag.
// Reset: controller kind MBC1, cartridge RAM present, ROM bank 1, RAM mapped
// at bank 0 but disabled, latch_armed flag set, both stages empty.
`default_nettype none

module cartridge_bank_controller
	import cbc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_item,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic        valid_s1;
	in_item_t    item_s1;
	logic        valid_s2;
	out_item_t   res_s2;
	logic [1:0]  kind_q;
	logic        has_ram_q;
	bank_state_t st_q;
	bank_state_t st_nxt;
	step_flags_t flags;
	logic        adv;

	cbc_next_state u_next (
		.kind  (kind_q),
		.cur   (st_q),
		.item  (item_s1),
		.nxt   (st_nxt),
		.flags (flags)
	);

	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	// configuration and bank state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q              <= KIND_MBC1;
			has_ram_q           <= 1'b1;
			st_q.rom_bank       <= ROM_BANK_RESET;
			st_q.ram_sel        <= 8'd0;
			st_q.ram_en         <= 1'b0;
			st_q.ram_attached   <= 1'b1;
			st_q.mapped_bank    <= 4'd0;
			st_q.mode           <= 1'b0;
			st_q.latch_armed    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CONTROLLER_KIND: kind_q <= cfg_wdata[1:0];
				default: begin
					has_ram_q         <= cfg_wdata[0];
					st_q.ram_attached <= cfg_wdata[0];
				end
			endcase
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2.rom_bank          <= st_nxt.rom_bank;
			res_s2.ram_active        <= st_nxt.ram_en;
			res_s2.ram_attached      <= st_nxt.ram_attached;
			res_s2.mapped_ram_bank   <= st_nxt.mapped_bank;
			res_s2.selected_ram_bank <= st_nxt.ram_sel;
			res_s2.latch_pulse       <= flags.pulse;
			res_s2.write_error       <= flags.err;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = res_s2;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input stage");

	a_adv_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("advanced item did not reach result stage");

	a_state_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !cfg_we) |=> (st_q == $past(st_nxt)))
		else $error("bank state did not take decoded update");

	a_no_kind_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !cfg_we && (kind_q == KIND_NONE)) |=> $stable(st_q))
		else $error("bank state changed with no controller");

	a_err_only_none: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && flags.err) |-> (kind_q == KIND_NONE && !has_ram_q) || (kind_q == KIND_NONE))
		else $error("write error raised with a controller configured");

endmodule : cartridge_bank_controller

`default_nettype wire
